[design/mcsp_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mcsp_pkg: shared definitions of the set partition search core
// Constants, register indexes, command codes and controller/datapath structs.
// ---------------------------------------------------------------------------
package mcsp_pkg;

   localparam int MAX_ELEMENTS = 8;
   localparam int COST_WIDTH   = 32;

   localparam int MASK_W      = MAX_ELEMENTS;
   localparam int LBL_W       = $clog2(MAX_ELEMENTS);
   localparam int CNT_W       = $clog2(MAX_ELEMENTS + 1);
   localparam int TABLE_DEPTH = (1 << MAX_ELEMENTS) - 1;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int IN_COST_W   = 32;
   localparam int BOUND_W     = 32;
   localparam int SUM_W       = 35;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 32;

   localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

   localparam logic [CNT_W-1:0]          ELEMENT_COUNT_RESET = CNT_W'(MAX_ELEMENTS);
   localparam logic signed [BOUND_W-1:0] START_BOUND_RESET   = 32'sd655360000;

   localparam logic [CSR_IDX_W-1:0] CSR_ELEMENT_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_BOUND   = 1'b1;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_RUN  = 1'b1;

   typedef struct packed {
      logic load;       // write the accepted cost entry
      logic start;      // initialize a run
      logic issue;      // read the cost of the next block
      logic eval;       // compare the sum and step to the next partition
      logic emit_next;  // move to the next result
   } dp_cmd_type;

   typedef struct packed {
      logic last_issue;   // current read is for the last block
      logic has_next;     // another partition follows the current one
      logic last_result;  // current result is the final one of the run
   } dp_status_type;

endpackage

[design/mcsp_if.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mcsp_if: request and response channel interfaces
// Valid/ready channels carrying the command items and the result items.
// ---------------------------------------------------------------------------
interface mcsp_req_if;
   import mcsp_pkg::*;

   logic                        valid;
   logic                        ready;
   logic                        cmd;
   logic [MASK_W-1:0]           subset_mask;
   logic signed [IN_COST_W-1:0] subset_cost;

   modport source (output valid, output cmd, output subset_mask, output subset_cost,
                   input ready);
   modport sink   (input valid, input cmd, input subset_mask, input subset_cost,
                   output ready);
endinterface

interface mcsp_rsp_if;
   import mcsp_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [MASK_W-1:0]       block_mask;
   logic signed [SUM_W-1:0] best_cost;
   logic [CNT_W-1:0]        block_total;
   logic                    found;
   logic                    last_block;

   modport source (output valid, output block_mask, output best_cost, output block_total,
                   output found, output last_block, input ready);
   modport sink   (input valid, input block_mask, input best_cost, input block_total,
                   input found, input last_block, output ready);
endinterface

[design/mcsp_ram.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mcsp_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module mcsp_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 255,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/mcsp_datapath.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mcsp_datapath: labels, cost accumulation and best-partition registers
// Holds the configuration, the cost table, the restricted growth string,
// the running sum and the best partition found so far.
// ---------------------------------------------------------------------------
module mcsp_datapath #(
   parameter int COST_WIDTH = mcsp_pkg::COST_WIDTH
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      csr_wr_en,
   input  logic [mcsp_pkg::CSR_IDX_W-1:0]            csr_index,
   input  logic [mcsp_pkg::CSR_DATA_W-1:0]           csr_wr_data,
   input  logic [mcsp_pkg::MASK_W-1:0]               in_mask,
   input  logic signed [mcsp_pkg::IN_COST_W-1:0]     in_cost,
   input  mcsp_pkg::dp_cmd_type                      cmd,
   output mcsp_pkg::dp_status_type                   status,
   output logic [mcsp_pkg::MASK_W-1:0]               out_block_mask,
   output logic signed [mcsp_pkg::SUM_W-1:0]         out_best_cost,
   output logic [mcsp_pkg::CNT_W-1:0]                out_block_total,
   output logic                                      out_found,
   output logic                                      out_last_block
);
   import mcsp_pkg::*;

   localparam int ACC_W = (COST_WIDTH + 4 > SUM_W + 1) ? COST_WIDTH + 4 : SUM_W + 1;
   localparam int EXT_W = (COST_WIDTH > IN_COST_W) ? COST_WIDTH : IN_COST_W;
   localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(SUM_MAX);
   localparam logic signed [ACC_W-1:0] ACC_MIN = ACC_W'(SUM_MIN);

   logic [CNT_W-1:0]          elem_count_ff, elem_count_in;
   logic signed [BOUND_W-1:0] start_bound_ff, start_bound_in;
   logic [CNT_W-1:0]          n_ff, n_in;
   logic [LBL_W-1:0]          labels_ff [MAX_ELEMENTS];
   logic [LBL_W-1:0]          labels_in [MAX_ELEMENTS];
   logic [LBL_W-1:0]          k_ff, k_in;
   logic [LBL_W-1:0]          out_k_ff, out_k_in;
   logic                      rd_valid_ff, rd_valid_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic signed [SUM_W-1:0]   best_sum_ff, best_sum_in;
   logic [CNT_W-1:0]          best_blocks_ff, best_blocks_in;
   logic [MASK_W-1:0]         best_masks_ff [MAX_ELEMENTS];
   logic [MASK_W-1:0]         best_masks_in [MAX_ELEMENTS];

   logic [MASK_W-1:0]         cur_mask [MAX_ELEMENTS];
   logic [CNT_W-1:0]          cur_blocks;
   logic [LBL_W-1:0]          prefix_max;
   logic                      has_next;
   logic [LBL_W-1:0]          adv_idx;
   logic signed [SUM_W-1:0]   clamped_sum;
   logic [EXT_W-1:0]          cost_ext;
   logic [COST_WIDTH-1:0]     rd_data;
   logic [MASK_W-1:0]         rd_mask;
   logic                      table_wr_en;
   logic [CNT_W-1:0]          n_start;
   logic                      found;

   // Cost table: only non-empty masks inside the table are stored.
   assign cost_ext    = EXT_W'(unsigned'(in_cost));
   assign table_wr_en = cmd.load && (in_mask != '0)
                        && (ADDR_W'(in_mask) <= ADDR_W'(TABLE_DEPTH));
   assign rd_mask     = cur_mask[k_ff];

   mcsp_ram #(
      .WIDTH  (COST_WIDTH),
      .DEPTH  (TABLE_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_cost_table (
      .clock   (clock),
      .wr_en   (table_wr_en),
      .wr_addr (ADDR_W'(in_mask - MASK_W'(1))),
      .wr_data (cost_ext[COST_WIDTH-1:0]),
      .rd_en   (cmd.issue),
      .rd_addr (ADDR_W'(rd_mask - MASK_W'(1))),
      .rd_data (rd_data)
   );

   // Block masks and block count of the current labels.
   always_comb begin
      cur_blocks = '0;
      for (int b = 0; b < MAX_ELEMENTS; b++) begin
         cur_mask[b] = '0;
      end
      for (int p = 0; p < MAX_ELEMENTS; p++) begin
         if (CNT_W'(p) < n_ff) begin
            cur_mask[labels_ff[p]] = cur_mask[labels_ff[p]]
               | (MASK_W'(1) << (n_ff - CNT_W'(p) - CNT_W'(1)));
            if (CNT_W'(labels_ff[p]) + CNT_W'(1) > cur_blocks) begin
               cur_blocks = CNT_W'(labels_ff[p]) + CNT_W'(1);
            end
         end
      end
   end

   // Rightmost position that may still grow, against the maximum to its left.
   always_comb begin
      prefix_max = '0;
      has_next   = 1'b0;
      adv_idx    = '0;
      for (int i = 1; i < MAX_ELEMENTS; i++) begin
         if (labels_ff[i-1] > prefix_max) begin
            prefix_max = labels_ff[i-1];
         end
         if ((CNT_W'(i) < n_ff) && (labels_ff[i] <= prefix_max)) begin
            has_next = 1'b1;
            adv_idx  = LBL_W'(i);
         end
      end
   end

   always_comb begin
      if (acc_ff > ACC_MAX) begin
         clamped_sum = SUM_MAX;
      end else if (acc_ff < ACC_MIN) begin
         clamped_sum = SUM_MIN;
      end else begin
         clamped_sum = acc_ff[SUM_W-1:0];
      end
   end

   always_comb begin
      if (elem_count_ff == '0) begin
         n_start = CNT_W'(1);
      end else if (elem_count_ff > CNT_W'(MAX_ELEMENTS)) begin
         n_start = CNT_W'(MAX_ELEMENTS);
      end else begin
         n_start = elem_count_ff;
      end
   end

   always_comb begin
      elem_count_in  = elem_count_ff;
      start_bound_in = start_bound_ff;
      n_in           = n_ff;
      labels_in      = labels_ff;
      k_in           = k_ff;
      out_k_in       = out_k_ff;
      rd_valid_in    = cmd.issue;
      acc_in         = acc_ff;
      best_sum_in    = best_sum_ff;
      best_blocks_in = best_blocks_ff;
      best_masks_in  = best_masks_ff;

      if (csr_wr_en) begin
         case (csr_index)
            CSR_ELEMENT_COUNT: elem_count_in  = csr_wr_data[CNT_W-1:0];
            CSR_START_BOUND:   start_bound_in = csr_wr_data[BOUND_W-1:0];
            default:           ;
         endcase
      end

      if (rd_valid_ff) begin
         acc_in = acc_ff + ACC_W'(signed'(rd_data));
      end
      if (cmd.issue) begin
         k_in = k_ff + LBL_W'(1);
      end

      if (cmd.start) begin
         n_in           = n_start;
         k_in           = '0;
         out_k_in       = '0;
         acc_in         = '0;
         best_sum_in    = SUM_W'(start_bound_ff);
         best_blocks_in = '0;
         for (int j = 0; j < MAX_ELEMENTS; j++) begin
            labels_in[j]     = '0;
            best_masks_in[j] = '0;
         end
      end

      if (cmd.eval) begin
         k_in   = '0;
         acc_in = '0;
         if (clamped_sum < best_sum_ff) begin
            best_sum_in    = clamped_sum;
            best_blocks_in = cur_blocks;
            best_masks_in  = cur_mask;
         end
         for (int j = 0; j < MAX_ELEMENTS; j++) begin
            if (LBL_W'(j) == adv_idx) begin
               labels_in[j] = labels_ff[j] + LBL_W'(1);
            end else if (LBL_W'(j) > adv_idx) begin
               labels_in[j] = '0;
            end
         end
      end

      if (cmd.emit_next) begin
         out_k_in = out_k_ff + LBL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         elem_count_ff  <= ELEMENT_COUNT_RESET;
         start_bound_ff <= START_BOUND_RESET;
         n_ff           <= CNT_W'(MAX_ELEMENTS);
         k_ff           <= '0;
         out_k_ff       <= '0;
         rd_valid_ff    <= 1'b0;
         acc_ff         <= '0;
         best_sum_ff    <= SUM_W'(START_BOUND_RESET);
         best_blocks_ff <= '0;
         for (int j = 0; j < MAX_ELEMENTS; j++) begin
            labels_ff[j]     <= '1;
            best_masks_ff[j] <= '0;
         end
      end else begin
         elem_count_ff  <= elem_count_in;
         start_bound_ff <= start_bound_in;
         n_ff           <= n_in;
         k_ff           <= k_in;
         out_k_ff       <= out_k_in;
         rd_valid_ff    <= rd_valid_in;
         acc_ff         <= acc_in;
         best_sum_ff    <= best_sum_in;
         best_blocks_ff <= best_blocks_in;
         labels_ff      <= labels_in;
         best_masks_ff  <= best_masks_in;
      end
   end

   assign found              = (best_blocks_ff != '0);
   assign status.last_issue  = (CNT_W'(k_ff) + CNT_W'(1) == cur_blocks);
   assign status.has_next    = has_next;
   assign status.last_result = !found || (CNT_W'(out_k_ff) + CNT_W'(1) == best_blocks_ff);

   assign out_block_mask  = found ? best_masks_ff[out_k_ff] : '0;
   assign out_best_cost   = best_sum_ff;
   assign out_block_total = best_blocks_ff;
   assign out_found       = found;
   assign out_last_block  = status.last_result;

`ifndef SYNTHESIS
   // The best sum can only fall while a run evaluates partitions.
   assert property (@(posedge clock) disable iff (reset)
      cmd.eval |=> (best_sum_ff <= $past(best_sum_ff)))
      else $error("best sum rose during evaluation");

   // All reads of the partition must be summed before it is evaluated.
   assert property (@(posedge clock) disable iff (reset)
      cmd.eval |-> !rd_valid_ff)
      else $error("cost read still pending at evaluation");

   // Block reads never run past the block count.
   assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> (CNT_W'(k_ff) < cur_blocks))
      else $error("cost read beyond last block");

   // A stored best partition always has element zero in its first block.
   assert property (@(posedge clock) disable iff (reset)
      (best_blocks_ff != '0) |-> (best_masks_ff[0] != '0))
      else $error("best partition has an empty first block");
`endif

endmodule

[design/mcsp_controller.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mcsp_controller: sequencing state machine of the partition search
// Takes items, walks partitions block by block and hands out the results.
// ---------------------------------------------------------------------------
module mcsp_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_cmd,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  mcsp_pkg::dp_status_type status,
   output mcsp_pkg::dp_cmd_type    cmd
);
   import mcsp_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_DRAIN,
      ST_EVAL,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      req_fire;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_EMIT);
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      state_in      = state_ff;
      cmd.load      = 1'b0;
      cmd.start     = 1'b0;
      cmd.issue     = 1'b0;
      cmd.eval      = 1'b0;
      cmd.emit_next = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_cmd == CMD_RUN) begin
                  cmd.start = 1'b1;
                  state_in  = ST_SUM;
               end else begin
                  cmd.load = 1'b1;
               end
            end
         end
         ST_SUM: begin
            cmd.issue = 1'b1;
            if (status.last_issue) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            state_in = status.has_next ? ST_SUM : ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_ready) begin
               if (status.last_result) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.emit_next = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTHESIS
   // A run always starts with a block read in the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> cmd.issue)
      else $error("run start not followed by a block read");

   // The last block read of a partition is followed by a drain and an evaluation.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.issue && status.last_issue) |=> ##1 cmd.eval)
      else $error("evaluation did not follow the last block read");

   // No item is taken while results are being handed out.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input ready while results pending");
`endif

endmodule

[design/min_cost_set_partition_search_core.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// min_cost_set_partition_search_core: minimum-cost set partition search
// Loads block costs per subset mask and, on a run, walks every set partition
// as a restricted growth string and reports the cheapest partition's blocks.
// ---------------------------------------------------------------------------
//
// Channel   Direction  Handshake      Carries
// req_ch    in         valid/ready    cmd, subset_mask, subset_cost
// rsp_ch    out        valid/ready    block_mask, best_cost, block_total,
//                                     found, last_block
// csr_*     in         write enable   element_count (0), start_bound (1)
//
// A load item is written to the cost table on acceptance; the core stays ready.
// A run item visits all Bell(n) partitions; for each one the single read port
// of the cost table reads one block cost per cycle, followed by a drain and an
// evaluation state. The run then emits one result per block (or one empty
// result), one per cycle while rsp_ch is ready.
// Reset is synchronous and active high; the cost table is not cleared.
// No new item is taken from the start of a run until its last result leaves.
// ---------------------------------------------------------------------------
module min_cost_set_partition_search_core #(
   parameter int COST_WIDTH = mcsp_pkg::COST_WIDTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [mcsp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [mcsp_pkg::CSR_DATA_W-1:0]   csr_wr_data,
   mcsp_req_if.sink                          req_ch,
   mcsp_rsp_if.source                        rsp_ch
);
   import mcsp_pkg::*;

   // Command and status between the state machine and the datapath.
   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   // The controller owns the handshakes; the datapath owns all payload.
   mcsp_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_cmd   (req_ch.cmd),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (dp_status),
      .cmd       (dp_cmd)
   );

   // The datapath also holds the configuration registers; the user must write
   // them only while the block is idle, which the block does not enforce.
   mcsp_datapath #(
      .COST_WIDTH (COST_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data),
      .in_mask         (req_ch.subset_mask),
      .in_cost         (req_ch.subset_cost),
      .cmd             (dp_cmd),
      .status          (dp_status),
      .out_block_mask  (rsp_ch.block_mask),
      .out_best_cost   (rsp_ch.best_cost),
      .out_block_total (rsp_ch.block_total),
      .out_found       (rsp_ch.found),
      .out_last_block  (rsp_ch.last_block)
   );

endmodule

[bench/min_cost_set_partition_search_core_test.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// min_cost_set_partition_search_core_test: self-checking bench of the core
// Loads block costs, runs exhaustive partition searches under several
// element counts and bounds, and checks every result item against a
// restricted-growth-string predictor kept inside the bench or a hand-typed result.
// ---------------------------------------------------------------------------
module min_cost_set_partition_search_core_test;
   import mcsp_pkg::*;

   // Clock period is 4 ns. The reset is held from time zero.
   localparam int RESET_CYCLES = 3;
   // A load leaves the core idle and ready, so the quiet wait of
   // SETTLE_CYCLES is enough before a register write.
   localparam int SETTLE_CYCLES = 4;
   localparam int END_SETTLE_CYCLES = 32;
   // The slowest search walks Bell(8) = 4140 partitions with no handshake at
   // all; the watchdog allows several times its length.
   localparam int WATCHDOG_LIMIT = 250000;
   localparam int NUM_PHASES = 14;
   // Filling the whole table for eight elements already takes most of the
   // item budget, so each phase adds only a short random mix.
   localparam int ITEMS_PER_PHASE = 1;

   typedef struct packed {
      logic [MASK_W-1:0]       block_mask;
      logic signed [SUM_W-1:0] best_cost;
      logic [CNT_W-1:0]        block_total;
      logic                    found;
      logic                    last_block;
   } block_result_type;

   typedef enum logic {ROW_CSR, ROW_ITEM} row_kind_type;

   // One row of the directed table: either a register write or an item.
   // Rows flagged as checked carry an expected result typed in by hand.
   typedef struct {
      row_kind_type             kind;
      logic [CSR_IDX_W-1:0]     index;
      logic [CSR_DATA_W-1:0]    data;
      logic                     cmd;
      logic [MASK_W-1:0]        mask;
      logic [IN_COST_W-1:0]     cost;
      bit                       checked;
      block_result_type         result;
   } stim_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   mcsp_req_if req_ch ();
   mcsp_rsp_if rsp_ch ();

   min_cost_set_partition_search_core u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch)
   );

   // Bench copy of the core's programmable state. The cost table is indexed
   // by subset mask; written_mask tracks which entries have been loaded so
   // that a search never reads an entry the core has not been given.
   longint           cost_tab [1:TABLE_DEPTH];
   bit               written_mask [1:TABLE_DEPTH];
   logic [3:0]       count_reg = ELEMENT_COUNT_RESET;
   longint           bound_reg = longint'(START_BOUND_RESET);

   block_result_type expected_blocks_q [$];
   stim_row_type     directed_rows [$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int error_count = 0;
   int load_items = 0;
   int run_items = 0;
   int results_seen = 0;
   int found_runs = 0;
   int empty_runs = 0;
   int widest_n = 0;
   int quiet_cycles = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic block_result_type make_result(input logic [MASK_W-1:0] mask,
                                                    input longint cost, input int total,
                                                    input logic found, input logic last);
      block_result_type r;
      r.block_mask  = mask;
      r.best_cost   = cost[SUM_W-1:0];
      r.block_total = total[CNT_W-1:0];
      r.found       = found;
      r.last_block  = last;
      return r;
   endfunction

   // Walks every set partition of the effective element count as a
   // restricted growth string in lexicographic order and queues the block
   // masks of the first partition with the lowest saturated sum, if it lies
   // strictly below the bound. When nothing beats it, one empty item is queued instead.
   function automatic void predict_partition_search();
      int                n, p, k, i, j, peak, blocks, best_total;
      int                labels [MAX_ELEMENTS];
      logic [MASK_W-1:0] cur [MAX_ELEMENTS];
      logic [MASK_W-1:0] best [MAX_ELEMENTS];
      longint            sum, best_sum;
      bit                stepped;
      // An element count of zero means one; anything above the maximum
      // saturates.
      n = (count_reg == 0) ? 1 : (count_reg > MAX_ELEMENTS) ? MAX_ELEMENTS : int'(count_reg);
      if (n > widest_n) widest_n = n;
      for (p = 0; p < MAX_ELEMENTS; p++) begin
         labels[p] = 0;
         best[p] = '0;
      end
      best_sum = bound_reg;
      best_total = 0;
      do begin
         blocks = 0;
         for (k = 0; k < MAX_ELEMENTS; k++) cur[k] = '0;
         // Element p lands on mask bit n-1-p of the block named by its label.
         for (p = 0; p < n; p++) begin
            cur[labels[p]][n - 1 - p] = 1'b1;
            if (labels[p] + 1 > blocks) blocks = labels[p] + 1;
         end
         sum = 0;
         for (k = 0; k < blocks; k++) sum += cost_tab[cur[k]];
         if (sum > longint'(SUM_MAX)) sum = longint'(SUM_MAX);
         if (sum < longint'(SUM_MIN)) sum = longint'(SUM_MIN);
         if (sum < best_sum) begin
            best_sum = sum;
            best_total = blocks;
            best = cur;
         end
         // Step to the next growth string: bump the rightmost label that
         // does not exceed the largest label to its left, zero the rest.
         stepped = 1'b0;
         for (i = n - 1; i >= 1 && !stepped; i--) begin
            peak = 0;
            for (j = 0; j < i; j++) if (labels[j] > peak) peak = labels[j];
            if (labels[i] <= peak) begin
               labels[i]++;
               for (j = i + 1; j < n; j++) labels[j] = 0;
               stepped = 1'b1;
            end
         end
      end while (stepped);
      if (best_total == 0) begin
         expected_blocks_q = {expected_blocks_q, make_result('0, best_sum, 0, 1'b0, 1'b1)};
      end else begin
         for (k = 0; k < best_total; k++)
            expected_blocks_q = {expected_blocks_q,
                                 make_result(best[k], best_sum, best_total, 1'b1,
                                             k == best_total - 1)};
      end
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("MISMATCH at %0t ns: %s: got %0d, expected %0d", $time, what, got, want);
      error_count++;
   endtask

   // Lowers the request valid and holds off until every queued result has
   // come back. The loop waits on the clock before its first check, so valid
   // is never dropped and raised again in the same time step.
   task automatic wait_drain();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (expected_blocks_q.size() != 0);
   endtask

   // Registers are only written once the core is idle.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      wait_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_ELEMENT_COUNT) count_reg = data[3:0];
      else bound_reg = longint'(signed'(data));
   endtask

   // Offers one item, with random idle cycles ahead of it, and on acceptance
   // updates the cost table or queues the expected results of a search.
   task automatic send_item(input logic cmd, input logic [MASK_W-1:0] mask,
                            input logic [IN_COST_W-1:0] cost, input bit checked,
                            input block_result_type result);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.cmd         <= cmd;
      req_ch.subset_mask <= mask;
      req_ch.subset_cost <= cost;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (cmd == CMD_LOAD) begin
         load_items++;
         // A load to the empty mask is dropped by the core.
         if (mask != 0) begin
            cost_tab[mask] = longint'(signed'(cost));
            written_mask[mask] = 1'b1;
         end
      end else begin
         run_items++;
         if (checked) expected_blocks_q = {expected_blocks_q, result};
         else predict_partition_search();
      end
   endtask

   function automatic void add_csr(input logic [CSR_IDX_W-1:0] idx,
                                   input logic [CSR_DATA_W-1:0] data);
      stim_row_type row;
      row.kind    = ROW_CSR;
      row.index   = idx;
      row.data    = data;
      row.cmd     = CMD_LOAD;
      row.mask    = '0;
      row.cost    = '0;
      row.checked = 1'b0;
      row.result  = '0;
      directed_rows = {directed_rows, row};
   endfunction

   function automatic void add_item(input logic cmd, input logic [MASK_W-1:0] mask,
                                    input logic [IN_COST_W-1:0] cost);
      stim_row_type row;
      row.kind    = ROW_ITEM;
      row.index   = '0;
      row.data    = '0;
      row.cmd     = cmd;
      row.mask    = mask;
      row.cost    = cost;
      row.checked = 1'b0;
      row.result  = '0;
      directed_rows = {directed_rows, row};
   endfunction

   function automatic void add_checked_run(input block_result_type result);
      stim_row_type row;
      row.kind    = ROW_ITEM;
      row.index   = '0;
      row.data    = '0;
      row.cmd     = CMD_RUN;
      row.mask    = '0;
      row.cost    = '0;
      row.checked = 1'b1;
      row.result  = result;
      directed_rows = {directed_rows, row};
   endfunction

   // Cost styles: full-range random, small values so that partitions
   // compete closely, and a constant so that ties decide the winner. A few
   // picks take a 32-bit extreme whatever the style.
   function automatic logic [IN_COST_W-1:0] pick_cost(input int style);
      int offset;
      if ($urandom_range(9) < 2) return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      case (style)
         0: return $urandom();
         1: begin
            offset = $urandom_range(2000);
            offset = offset - 1000;
            return offset << 8;
         end
         default: return 32'h0001_0000;
      endcase
   endfunction

   // The result channel stalls at random; each accepted item is compared
   // with the oldest queued expectation, field by field.
   task automatic check_result();
      block_result_type want;
      results_seen++;
      if (rsp_ch.last_block) begin
         if (rsp_ch.found) found_runs++;
         else empty_runs++;
      end
      if (expected_blocks_q.size() == 0) begin
         report_mismatch("result item with nothing pending, block_mask",
                         longint'(rsp_ch.block_mask), 0);
         return;
      end
      want = expected_blocks_q.pop_front();
      if (rsp_ch.block_mask !== want.block_mask)
         report_mismatch("block_mask", longint'(rsp_ch.block_mask),
                         longint'(want.block_mask));
      if (rsp_ch.best_cost !== want.best_cost)
         report_mismatch("best_cost", longint'(rsp_ch.best_cost), longint'(want.best_cost));
      if (rsp_ch.block_total !== want.block_total)
         report_mismatch("block_total", longint'(rsp_ch.block_total),
                         longint'(want.block_total));
      if (rsp_ch.found !== want.found)
         report_mismatch("found", longint'(rsp_ch.found), longint'(want.found));
      if (rsp_ch.last_block !== want.last_block)
         report_mismatch("last_block", longint'(rsp_ch.last_block),
                         longint'(want.last_block));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) check_result();
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // The watchdog counts cycles in which neither channel moves an item.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog expired after %0d cycles without a handshake.", quiet_cycles);
         $display("min_cost_set_partition_search_core regression: fail");
         $finish;
      end
   end

   initial begin
      int                    phase, k, roll, n_eff, style, runs, run_cap;
      int unsigned           m;
      logic [CSR_DATA_W-1:0] count_word, bound_word;
      int                    offset;

      req_ch.valid       <= 1'b0;
      req_ch.cmd         <= CMD_LOAD;
      req_ch.subset_mask <= '0;
      req_ch.subset_cost <= '0;
      csr_wr_en          <= 1'b0;
      csr_index          <= '0;
      csr_wr_data        <= '0;

      // Directed table. With one element the only partition is the single
      // block of mask 1, so the expected result can be read off directly.
      // The first search runs with the start bound still at its reset value.
      add_csr(CSR_ELEMENT_COUNT, 32'd1);
      add_item(CMD_LOAD, 8'h01, 32'h0000_0000);
      add_checked_run(make_result(8'h01, 0, 1, 1'b1, 1'b1));
      // A cost equal to the bound does not beat it: one empty item.
      add_item(CMD_LOAD, 8'h01, 32'd655360000);
      add_checked_run(make_result(8'h00, 655360000, 0, 1'b0, 1'b1));
      add_item(CMD_LOAD, 8'h01, 32'd655359999);
      add_checked_run(make_result(8'h01, 655359999, 1, 1'b1, 1'b1));
      // Most negative bound and cost: still not strictly below.
      add_csr(CSR_START_BOUND, 32'h8000_0000);
      add_item(CMD_LOAD, 8'h01, 32'h8000_0000);
      add_checked_run(make_result(8'h00, -64'sd2147483648, 0, 1'b0, 1'b1));
      add_csr(CSR_START_BOUND, 32'h7FFF_FFFF);
      add_checked_run(make_result(8'h01, -64'sd2147483648, 1, 1'b1, 1'b1));
      add_item(CMD_LOAD, 8'h01, 32'h7FFF_FFFF);
      add_checked_run(make_result(8'h00, 64'sd2147483647, 0, 1'b0, 1'b1));
      // A load to the empty mask must leave the table alone.
      add_item(CMD_LOAD, 8'h00, 32'h8000_0000);
      add_checked_run(make_result(8'h00, 64'sd2147483647, 0, 1'b0, 1'b1));
      // An element count of zero is taken as one.
      add_csr(CSR_ELEMENT_COUNT, 32'd0);
      add_item(CMD_RUN, 8'hFF, 32'hFFFF_FFFF);
      // Two and three elements, checked by the predictor.
      add_csr(CSR_ELEMENT_COUNT, 32'd2);
      add_csr(CSR_START_BOUND, START_BOUND_RESET);
      add_item(CMD_LOAD, 8'h01, 32'd6553600);
      add_item(CMD_LOAD, 8'h02, 32'd13107200);
      add_item(CMD_LOAD, 8'h03, 32'd16384000);
      add_item(CMD_RUN, 8'h00, 32'h0000_0000);
      add_csr(CSR_ELEMENT_COUNT, 32'd3);
      add_item(CMD_LOAD, 8'h04, 32'hFFF6_0000);
      add_item(CMD_LOAD, 8'h05, 32'h0005_0000);
      add_item(CMD_LOAD, 8'h06, 32'h7FFF_FFFF);
      add_item(CMD_LOAD, 8'h07, 32'h8000_0000);
      add_item(CMD_RUN, 8'h5A, 32'hA5A5_A5A5);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 36;
      recv_idle_pct = 77;
      foreach (directed_rows[r]) begin
         if (directed_rows[r].kind == ROW_CSR)
            write_csr(directed_rows[r].index, directed_rows[r].data);
         else
            send_item(directed_rows[r].cmd, directed_rows[r].mask, directed_rows[r].cost,
                      directed_rows[r].checked, directed_rows[r].result);
      end

      // Random phases. Each one picks a register setting, makes sure every
      // cost entry the search can touch has been loaded, then mixes loads,
      // searches and a little noise. The idling pattern changes by thirds.
      for (phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase * 3 / NUM_PHASES)
            0: begin
               send_idle_pct = 36;
               recv_idle_pct = 77;
            end
            1: begin
               send_idle_pct = 77;
               recv_idle_pct = 36;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase

         // The upper bits of the element count write are random; only the
         // low four bits matter. Zero and values above eight appear too.
         count_word = $urandom();
         case (phase)
            3:       count_word[3:0] = 4'd15;
            5:       count_word[3:0] = 4'd0;
            7:       count_word[3:0] = 4'd7;
            11:      count_word[3:0] = 4'd8;
            12:      count_word[3:0] = 4'd9;
            default: count_word[3:0] = 4'($urandom_range(1, 6));
         endcase
         case (phase)
            1:       bound_word = 32'h7FFF_FFFF;
            2:       bound_word = 32'h8000_0000;
            4:       bound_word = 32'h0000_0000;
            default: begin
               case ($urandom_range(2))
                  0: bound_word = $urandom();
                  1: begin
                     offset = $urandom_range(8000);
                     offset = offset - 4000;
                     bound_word = offset << 12;
                  end
                  default: bound_word = START_BOUND_RESET;
               endcase
            end
         endcase
         write_csr(CSR_ELEMENT_COUNT, count_word);
         write_csr(CSR_START_BOUND, bound_word);

         n_eff = count_word[3:0];
         if (n_eff == 0) n_eff = 1;
         else if (n_eff > MAX_ELEMENTS) n_eff = MAX_ELEMENTS;
         style = $urandom_range(2);

         for (m = 1; m < (1 << n_eff); m++)
            if (!written_mask[m]) send_item(CMD_LOAD, m[MASK_W-1:0], pick_cost(style), 1'b0, '0);

         // Searches over seven or eight elements are long, so few of them.
         run_cap = (n_eff == 8) ? 1 : (n_eff == 7) ? 2 : 8;
         runs = 0;
         for (k = 0; k < ITEMS_PER_PHASE; k++) begin
            roll = $urandom_range(99);
            if (roll < 8) begin
               send_item(CMD_LOAD, 8'h00, pick_cost(style), 1'b0, '0);
            end else if (roll < 40 && runs < run_cap) begin
               send_item(CMD_RUN, MASK_W'($urandom_range(255)), $urandom(), 1'b0, '0);
               runs++;
               // Now and then the sender waits for the whole search to drain.
               if ($urandom_range(3) == 0) wait_drain();
            end else if ($urandom_range(3) == 0) begin
               send_item(CMD_LOAD, MASK_W'($urandom_range(1, 255)), pick_cost(style),
                         1'b0, '0);
            end else begin
               send_item(CMD_LOAD, MASK_W'($urandom_range(1, (1 << n_eff) - 1)),
                         pick_cost(style), 1'b0, '0);
            end
         end
         send_item(CMD_RUN, MASK_W'($urandom_range(255)), $urandom(), 1'b0, '0);
      end

      wait_drain();
      repeat (END_SETTLE_CYCLES) @(posedge clock);
      if (expected_blocks_q.size() != 0)
         report_mismatch("expected result items left over",
                         longint'(expected_blocks_q.size()), 0);

      $display("Covered %0d cost loads and %0d searches over element counts up to %0d.",
               load_items, run_items, widest_n);
      $display("Checked %0d result items; %0d searches beat the bound and %0d did not.",
               results_seen, found_runs, empty_runs);
      if (error_count == 0) begin
         $display("min_cost_set_partition_search_core regression: pass");
      end else begin
         $display("min_cost_set_partition_search_core regression: fail");
      end
      $finish;
   end

endmodule
